### src/vde_pkg.sv
// ----------------------------------------------------------------------------
// vde_pkg
// Shared widths, metric codes, queue entry and back-end state type for the
// vector distance engine.
// ----------------------------------------------------------------------------
package vde_pkg;

	localparam int MAX_DIM_DEF = 256;
	localparam int QUEUE_DEPTH = 2;

	localparam int COORD_W = 16;
	localparam int SD_W    = 42;	// sum of squared differences
	localparam int SN_W    = 40;	// squared norms
	localparam int DOT_W   = 41;	// signed dot product
	localparam int SQ_W    = 58;	// sqrt radicand, SD_W + 16
	localparam int ROOT_W  = 29;	// sqrt result
	localparam int NR_W    = 28;	// norm root
	localparam int DEN_W   = 56;	// divisor
	localparam int Q_W     = 32;	// quotient bits
	localparam int RES_W   = 31;

	localparam logic [1:0] METRIC_EUCLID = 2'd0;
	localparam logic [1:0] METRIC_COSINE = 2'd1;
	localparam logic [1:0] METRIC_SIMIL  = 2'd2;
	localparam logic [1:0] METRIC_ZERO   = 2'd3;

	localparam logic [Q_W-1:0] ONE_Q16 = 32'd65536;

	typedef struct packed {
		logic [1:0]              mode;
		logic [SD_W-1:0]         sd;
		logic [SN_W-1:0]         s1;
		logic [SN_W-1:0]         s2;
		logic signed [DOT_W-1:0] dot;
	} acc_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ1,
		ST_SQ2,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} back_state_t;

endpackage

### src/vector_distance_engine_unit.sv
// ----------------------------------------------------------------------------
// vector_distance_engine_unit
// Euclidean distance, cosine distance and similarity of two Q8.8 vectors
// streamed one coordinate pair per item; result in unsigned Q15.16.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  ------------------------------------
//  input     in_valid / in_ready       coord_a, coord_b, last_element
//  config    cfg_valid / cfg_ready     metric_mode
//  result    result_valid/result_ready result_value, zero_norm
//
//  The front end takes one pair per cycle while the sum queue has room.
//  Per vector the back end runs a 29-step root for euclid, a root and a
//  32-step divide for similarity, two 29-step roots, a multiply and at most
//  a 32-step divide for cosine, none for metric 3 or a zero norm; the loop
//  in vde_back sets the sustained rate for short vectors.
//  Reset clears the sums, the queue and the result valid flag, metric = 0.
//  A stalled result holds the back end; the queue keeps the front running.
//
module vector_distance_engine_unit #(
	parameter int MAX_DIM     = vde_pkg::MAX_DIM_DEF,
	parameter int QUEUE_DEPTH = vde_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [vde_pkg::COORD_W-1:0] coord_a,
	input  logic signed [vde_pkg::COORD_W-1:0] coord_b,
	input  logic                               last_element,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         metric_mode,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [vde_pkg::RES_W-1:0]          result_value,
	output logic                               zero_norm
);
	import vde_pkg::*;

	acc_entry_t push_entry, pop_entry;
	logic       push_valid, not_full, not_empty, pop;

	// accumulators, one pair a cycle while the queue has room
	vde_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.coord_a      (coord_a),
		.coord_b      (coord_b),
		.last_element (last_element),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.metric_mode  (metric_mode),
		.push_valid   (push_valid),
		.push_entry   (push_entry),
		.push_ready   (not_full)
	);

	// finished sums wait here for the back end
	vde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.wr_entry  (push_entry),
		.not_full  (not_full),
		.pop       (pop),
		.rd_entry  (pop_entry),
		.not_empty (not_empty)
	);

	// roots, divide and result register
	vde_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (not_empty),
		.q_entry      (pop_entry),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_value (result_value),
		.zero_norm    (zero_norm)
	);

endmodule

### src/vde_front.sv
// ----------------------------------------------------------------------------
// vde_front
// Takes coordinate pairs, accumulates the four sums over at most MAX_DIM
// pairs and pushes them with the metric on the last pair.
// ----------------------------------------------------------------------------
module vde_front #(
	parameter int MAX_DIM = vde_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [vde_pkg::COORD_W-1:0] coord_a,
	input  logic signed [vde_pkg::COORD_W-1:0] coord_b,
	input  logic                              last_element,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        metric_mode,
	output logic                              push_valid,
	output vde_pkg::acc_entry_t               push_entry,
	input  logic                              push_ready
);
	import vde_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIM + 1);

	logic [1:0]              mode_q;
	logic [SD_W-1:0]         sd_q, sd_n;
	logic [SN_W-1:0]         s1_q, s1_n, s2_q, s2_n;
	logic signed [DOT_W-1:0] dot_q, dot_n;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [16:0]      diff;
	logic signed [33:0]      p_dd;
	logic signed [31:0]      p_aa, p_bb, p_ab;
	logic                    take, accept;

	assign in_ready  = push_ready;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign take      = cnt_q < CNT_W'(MAX_DIM);

	always_comb begin
		diff = {coord_a[15], coord_a} - {coord_b[15], coord_b};
		p_dd = diff * diff;
		p_aa = coord_a * coord_a;
		p_bb = coord_b * coord_b;
		p_ab = coord_a * coord_b;
		sd_n  = sd_q;
		s1_n  = s1_q;
		s2_n  = s2_q;
		dot_n = dot_q;
		if (take) begin
			sd_n  = sd_q + SD_W'(p_dd[31:0]);
			s1_n  = s1_q + SN_W'(p_aa[30:0]);
			s2_n  = s2_q + SN_W'(p_bb[30:0]);
			dot_n = dot_q + DOT_W'(p_ab);
		end
	end

	assign push_valid      = accept && last_element;
	assign push_entry.mode = mode_q;
	assign push_entry.sd   = sd_n;
	assign push_entry.s1   = s1_n;
	assign push_entry.s2   = s2_n;
	assign push_entry.dot  = dot_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= METRIC_EUCLID;
			sd_q   <= '0;
			s1_q   <= '0;
			s2_q   <= '0;
			dot_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_valid) begin
				mode_q <= metric_mode;
			end
			if (accept) begin
				if (last_element) begin
					sd_q  <= '0;
					s1_q  <= '0;
					s2_q  <= '0;
					dot_q <= '0;
					cnt_q <= '0;
				end else begin
					sd_q  <= sd_n;
					s1_q  <= s1_n;
					s2_q  <= s2_n;
					dot_q <= dot_n;
					if (take) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

### src/vde_queue.sv
// ----------------------------------------------------------------------------
// vde_queue
// Small FIFO of accumulated sums between front and back end.
// ----------------------------------------------------------------------------
module vde_queue #(
	parameter int DEPTH = vde_pkg::QUEUE_DEPTH	// 2 or more
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vde_pkg::acc_entry_t wr_entry,
	output logic                not_full,
	input  logic                pop,
	output vde_pkg::acc_entry_t rd_entry,
	output logic                not_empty
);
	import vde_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	acc_entry_t     mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign not_full  = cnt_q != CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/vde_back.sv
// ----------------------------------------------------------------------------
// vde_back
// Evaluates the metric for one queued vector pair: bit-serial square roots,
// one multiply and a one-bit-per-cycle divider, then the output register.
// ----------------------------------------------------------------------------
module vde_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  vde_pkg::acc_entry_t           q_entry,
	output logic                          q_pop,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [vde_pkg::RES_W-1:0]     result_value,
	output logic                          zero_norm
);
	import vde_pkg::*;

	back_state_t           state_q, state_n;
	acc_entry_t            ent_q;
	logic [SQ_W-1:0]       sq_v_q, sq_r_q, sq_bit_q;
	logic [SQ_W-1:0]       sq_trial, sq_v_n, sq_r_n;
	logic                  sq_ge, sq_last;
	logic [ROOT_W-1:0]     root;
	logic [NR_W-1:0]       rx_q, ry_q;
	logic [DEN_W-1:0]      den_q, rem_q, rem_n;
	logic [DEN_W:0]        rem_sh;
	logic                  div_ge;
	logic [Q_W-1:0]        q_q, q_clamp;
	logic [4:0]            cnt_q;
	logic [RES_W-1:0]      res_q, res_out_q;
	logic                  zero_q, zero_out_q, out_valid_q;
	logic                  load_out;

	// one step of the restoring square root
	always_comb begin
		sq_trial = sq_r_q + sq_bit_q;
		sq_ge    = sq_v_q >= sq_trial;
		sq_v_n   = sq_ge ? sq_v_q - sq_trial : sq_v_q;
		sq_r_n   = sq_ge ? (sq_r_q >> 1) + sq_bit_q : sq_r_q >> 1;
		root     = sq_r_n[ROOT_W-1:0];
		sq_last  = sq_bit_q[0];
	end

	// one quotient bit
	always_comb begin
		rem_sh = {rem_q, 1'b0};
		div_ge = rem_sh >= {1'b0, den_q};
		rem_n  = div_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
		q_clamp = (q_q > ONE_Q16) ? ONE_Q16 : q_q;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (q_not_empty) begin
				if (q_entry.mode == METRIC_ZERO) state_n = ST_OUT;
				else if (q_entry.mode == METRIC_COSINE &&
					(q_entry.s1 == '0 || q_entry.s2 == '0)) state_n = ST_OUT;
				else state_n = ST_SQ1;
			end
			ST_SQ1: if (sq_last) begin
				if (ent_q.mode == METRIC_EUCLID) state_n = ST_OUT;
				else if (ent_q.mode == METRIC_SIMIL) state_n = ST_DIV;
				else state_n = ST_SQ2;
			end
			ST_SQ2: if (sq_last) state_n = ST_MUL;
			ST_MUL: state_n = ST_CHK;
			ST_CHK: state_n = (rem_q >= den_q) ? ST_FIN : ST_DIV;
			ST_DIV: if (cnt_q == 5'd31) state_n = ST_FIN;
			ST_FIN: state_n = ST_OUT;
			ST_OUT: if (load_out) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == ST_IDLE) && q_not_empty;
		load_out = (state_q == ST_OUT) && (!out_valid_q || result_ready);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ent_q    <= q_entry;
				sq_r_q   <= '0;
				sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
				sq_v_q   <= (q_entry.mode == METRIC_COSINE) ?
					{2'b00, q_entry.s1, 16'd0} : {q_entry.sd, 16'd0};
				res_q    <= (q_entry.mode == METRIC_COSINE) ? RES_W'(ONE_Q16) : '0;
				zero_q   <= (q_entry.mode == METRIC_COSINE);
			end
			ST_SQ1: begin
				res_q    <= RES_W'(root);
				zero_q   <= 1'b0;
				rx_q     <= root[NR_W-1:0];
				den_q    <= DEN_W'(root) + DEN_W'(ONE_Q16);
				rem_q    <= DEN_W'(1);
				q_q      <= '0;
				cnt_q    <= '0;
				if (sq_last) begin
					sq_v_q   <= {2'b00, ent_q.s2, 16'd0};
					sq_r_q   <= '0;
					sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
				end else begin
					sq_v_q   <= sq_v_n;
					sq_r_q   <= sq_r_n;
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			ST_SQ2: begin
				sq_v_q   <= sq_v_n;
				sq_r_q   <= sq_r_n;
				sq_bit_q <= sq_bit_q >> 2;
				ry_q     <= root[NR_W-1:0];
			end
			ST_MUL: begin
				den_q <= rx_q * ry_q;
				rem_q <= ent_q.dot[DOT_W-1] ? DEN_W'(-ent_q.dot) : DEN_W'(ent_q.dot);
			end
			ST_CHK: begin
				q_q <= ONE_Q16;
			end
			ST_DIV: begin
				rem_q <= rem_n;
				cnt_q <= cnt_q + 1'b1;
				// first step starts the quotient afresh
				if (cnt_q == '0) begin
					q_q <= {{(Q_W-1){1'b0}}, div_ge};
				end else begin
					q_q <= {q_q[Q_W-2:0], div_ge};
				end
			end
			ST_FIN: begin
				if (ent_q.mode == METRIC_SIMIL) res_q <= q_q[RES_W-1:0];
				else if (ent_q.dot[DOT_W-1]) res_q <= RES_W'(ONE_Q16 + q_clamp);
				else res_q <= RES_W'(ONE_Q16 - q_clamp);
			end
			ST_OUT: begin
				if (load_out) begin
					res_out_q  <= res_q;
					zero_out_q <= zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result_value = res_out_q;
	assign zero_norm    = zero_out_q;

endmodule
